FILE: hw/rtl/mo3p_pkg.sv
package mo3p_pkg;

    // fixed field widths of the item ports
    localparam int INDEX_W = 10;
    localparam int DATA_W  = 32;

    // defaults for the top-level parameters
    localparam int STORE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    // command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_PART  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_BAD   = 2'd3
    } t_cmd;

    // partition engine status toward the command control
    typedef struct packed {
        logic busy;
        logic done;
    } t_part_sts;

endpackage

FILE: hw/rtl/mo3p_store.sv
module mo3p_store #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/mo3p_part.sv
module mo3p_part #(
    parameter int STORE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [$clog2(STORE_DEPTH)-1:0] i_start_idx,
    input  logic [$clog2(STORE_DEPTH)-1:0] i_end_idx,
    input  logic [VALUE_WIDTH-1:0]         i_rdata,
    output logic                           o_we,
    output logic [$clog2(STORE_DEPTH)-1:0] o_waddr,
    output logic [VALUE_WIDTH-1:0]         o_wdata,
    output logic [$clog2(STORE_DEPTH)-1:0] o_raddr,
    output logic [$clog2(STORE_DEPTH)-1:0] o_pos,
    output mo3p_pkg::t_part_sts            o_sts
);

    import mo3p_pkg::*;

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int AW1 = AW + 1;
    // scan pointers run from start-1 up to end+1
    localparam int IW  = AW + 2;

    typedef enum logic [4:0] {
        P_IDLE,
        P_RD_S,
        P_RD_M,
        P_RD_E,
        P_GET_E,
        P_MED1,
        P_MED2,
        P_MED3,
        P_SWP1,
        P_SWP2,
        P_SCAN_I,
        P_CMP_I,
        P_SCAN_J,
        P_CMP_J,
        P_CHECK,
        P_XCH1,
        P_XCH2,
        P_FIN_RD,
        P_FIN_GET,
        P_FIN_W2
    } t_pstate;

    t_pstate r_state;
    logic    r_done;

    logic [AW-1:0]          r_s, r_e, r_m, r_p, r_pos;
    logic [VALUE_WIDTH-1:0] r_vs, r_vm, r_ve, r_pv, r_vi, r_vj;
    logic                   r_g1;
    logic signed [IW-1:0]   r_i, r_j;

    logic [AW1-1:0]         mid_sum;
    logic signed [IW-1:0]   s_ext, e_ext;
    logic signed [VALUE_WIDTH-1:0] cmp_a, cmp_b;
    logic                   c_gt;

    assign mid_sum = AW1'(i_start_idx) + AW1'(i_end_idx);
    assign s_ext   = $signed(IW'(r_s));
    assign e_ext   = $signed(IW'(r_e));

    // shared signed comparator, operands picked by step
    always_comb begin
        cmp_a = $signed(r_vm);
        cmp_b = $signed(r_vs);
        case (r_state)
            P_MED2: begin
                cmp_a = $signed(r_ve);
                cmp_b = r_g1 ? $signed(r_vs) : $signed(r_vm);
            end
            P_MED3: begin
                cmp_a = r_g1 ? $signed(r_vm) : $signed(r_ve);
                cmp_b = r_g1 ? $signed(r_ve) : $signed(r_vs);
            end
            P_CMP_I: begin
                cmp_a = $signed(i_rdata);
                cmp_b = $signed(r_pv);
            end
            P_CMP_J: begin
                cmp_a = $signed(r_pv);
                cmp_b = $signed(i_rdata);
            end
            default: begin
                cmp_a = $signed(r_vm);
                cmp_b = $signed(r_vs);
            end
        endcase
    end

    assign c_gt = cmp_a > cmp_b;

    // store port drive per step
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_s;
        o_wdata = r_pv;
        o_raddr = r_s;
        case (r_state)
            P_RD_M:   o_raddr = r_m;
            P_RD_E:   o_raddr = r_e;
            P_SCAN_I: o_raddr = r_i[AW-1:0];
            P_SCAN_J: o_raddr = r_j[AW-1:0];
            P_FIN_RD: o_raddr = r_i[AW-1:0];
            P_SWP1: begin
                o_we    = 1'b1;
                o_waddr = r_p;
                o_wdata = r_vs;
            end
            P_SWP2: begin
                o_we    = 1'b1;
            end
            P_XCH1: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
                o_wdata = r_vj;
            end
            P_XCH2: begin
                o_we    = 1'b1;
                o_waddr = r_j[AW-1:0];
                o_wdata = r_vi;
            end
            P_FIN_GET: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
            end
            P_FIN_W2: begin
                o_we    = 1'b1;
                o_waddr = r_i[AW-1:0];
            end
            default: begin
                o_we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == P_FIN_W2);
            case (r_state)
                P_IDLE: begin
                    if (i_start) begin
                        r_s     <= i_start_idx;
                        r_e     <= i_end_idx;
                        r_m     <= mid_sum[AW:1];
                        r_state <= P_RD_S;
                    end
                end
                P_RD_S: r_state <= P_RD_M;
                P_RD_M: begin
                    r_vs    <= i_rdata;
                    r_state <= P_RD_E;
                end
                P_RD_E: begin
                    r_vm    <= i_rdata;
                    r_state <= P_GET_E;
                end
                P_GET_E: begin
                    r_ve    <= i_rdata;
                    r_state <= P_MED1;
                end
                P_MED1: begin
                    r_g1    <= c_gt;
                    r_state <= P_MED2;
                end
                P_MED2: begin
                    if (c_gt) begin
                        r_state <= P_MED3;
                    end else if (r_g1) begin
                        r_p     <= r_s;
                        r_pv    <= r_vs;
                        r_state <= P_SWP1;
                    end else begin
                        r_p     <= r_m;
                        r_pv    <= r_vm;
                        r_state <= P_SWP1;
                    end
                end
                P_MED3: begin
                    if (r_g1) begin
                        r_p  <= c_gt ? r_e : r_m;
                        r_pv <= c_gt ? r_ve : r_vm;
                    end else begin
                        r_p  <= c_gt ? r_s : r_e;
                        r_pv <= c_gt ? r_vs : r_ve;
                    end
                    r_state <= P_SWP1;
                end
                P_SWP1: r_state <= P_SWP2;
                P_SWP2: begin
                    r_i     <= s_ext;
                    r_j     <= e_ext;
                    r_state <= P_SCAN_I;
                end
                P_SCAN_I: begin
                    r_state <= (r_i < e_ext) ? P_CMP_I : P_SCAN_J;
                end
                P_CMP_I: begin
                    if (c_gt) begin
                        r_vi    <= i_rdata;
                        r_state <= P_SCAN_J;
                    end else begin
                        r_i     <= r_i + IW'(1);
                        r_state <= P_SCAN_I;
                    end
                end
                P_SCAN_J: begin
                    r_state <= (r_j > s_ext) ? P_CMP_J : P_CHECK;
                end
                P_CMP_J: begin
                    if (c_gt) begin
                        r_vj    <= i_rdata;
                        r_state <= P_CHECK;
                    end else begin
                        r_j     <= r_j - IW'(1);
                        r_state <= P_SCAN_J;
                    end
                end
                P_CHECK: begin
                    if (r_i > r_j) begin
                        r_i     <= r_i - IW'(1);
                        r_state <= P_FIN_RD;
                    end else if (r_i == r_j) begin
                        // swap with itself, just step both pointers
                        r_i     <= r_i + IW'(1);
                        r_j     <= r_j - IW'(1);
                        r_state <= P_SCAN_I;
                    end else begin
                        r_state <= P_XCH1;
                    end
                end
                P_XCH1: r_state <= P_XCH2;
                P_XCH2: begin
                    r_i     <= r_i + IW'(1);
                    r_j     <= r_j - IW'(1);
                    r_state <= P_SCAN_I;
                end
                P_FIN_RD:  r_state <= P_FIN_GET;
                P_FIN_GET: r_state <= P_FIN_W2;
                P_FIN_W2: begin
                    r_pos   <= r_i[AW-1:0];
                    r_state <= P_IDLE;
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    assign o_pos      = r_pos;
    assign o_sts.busy = (r_state != P_IDLE);
    assign o_sts.done = r_done;

endmodule

FILE: hw/rtl/median_of_three_partition.sv
// Element store with an in-place median-of-three quicksort partition. Items
// carry a command: write an element, read an element, or partition an
// inclusive range and return the pivot's final index. Every item gives one
// result; a bad index, a bad range or an unknown command returns status 1
// with zero fields and leaves the store untouched. One item at a time is
// worked. A partition first reads the first, middle and last elements,
// picks the median and moves it to the start; then the pointers compare
// elements against it up to the range bounds, the two pointers are checked
// and exchanges are made; finally the pivot is placed and the result handed
// out. The pace is set by the single shared comparator and the one read
// and one write port of the store, which the partition sequencer drives in
// turn. A finished result sits in the output register, so the next item is
// taken while it waits. The store has no reset; reading an element that was
// never written gives an undefined value.
module median_of_three_partition #(
    parameter int STORE_DEPTH = mo3p_pkg::STORE_DEPTH_DEF,
    parameter int VALUE_WIDTH = mo3p_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_command,
    input  logic [mo3p_pkg::INDEX_W-1:0]        i_element_index,
    input  logic signed [mo3p_pkg::DATA_W-1:0]  i_element_value,
    input  logic [mo3p_pkg::INDEX_W-1:0]        i_range_start,
    input  logic [mo3p_pkg::INDEX_W-1:0]        i_range_end,
    // result item channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [mo3p_pkg::DATA_W-1:0]  o_read_value,
    output logic [mo3p_pkg::INDEX_W-1:0]        o_pivot_position,
    output logic                                o_status
);

    import mo3p_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    // written values keep at most this many low bits, sign-extended
    localparam int EW = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_PART,
        T_DONE
    } t_tstate;

    t_tstate r_state;

    // result waiting for the output register
    logic signed [DATA_W-1:0] r_res_val;
    logic [INDEX_W-1:0]       r_res_pos;
    logic                     r_res_st;

    // output register
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_val;
    logic [INDEX_W-1:0]       r_out_pos;
    logic                     r_out_st;

    // store ports
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_wdata, mem_rdata;

    // partition engine
    logic                   part_start;
    logic                   part_we;
    logic [AW-1:0]          part_waddr, part_raddr, part_pos;
    logic [VALUE_WIDTH-1:0] part_wdata;
    t_part_sts              part_sts;

    logic  in_accept;
    logic  out_free;
    logic  idx_ok, rng_ok;
    t_cmd  cmd;

    assign cmd       = t_cmd'(i_command);
    assign o_stall   = (r_state != T_IDLE);
    assign in_accept = i_valid && !o_stall;

    // output register can take a result this cycle
    assign out_free  = !r_out_valid || !i_stall;

    assign idx_ok = 32'(i_element_index) < 32'(STORE_DEPTH);
    assign rng_ok = (i_range_start <= i_range_end) &&
                    (32'(i_range_end) < 32'(STORE_DEPTH));

    assign part_start = in_accept && (cmd == CMD_PART) && rng_ok;

    // store port: the partition engine owns it while busy
    always_comb begin
        if (part_sts.busy) begin
            mem_we    = part_we;
            mem_waddr = part_waddr;
            mem_wdata = part_wdata;
            mem_raddr = part_raddr;
        end else begin
            mem_we    = in_accept && (cmd == CMD_WRITE) && idx_ok;
            mem_waddr = AW'(i_element_index);
            mem_wdata = VALUE_WIDTH'($signed(i_element_value[EW-1:0]));
            mem_raddr = AW'(i_element_index);
        end
    end

    mo3p_store #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    mo3p_part #(
        .STORE_DEPTH (STORE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_part (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (part_start),
        .i_start_idx (AW'(i_range_start)),
        .i_end_idx   (AW'(i_range_end)),
        .i_rdata     (mem_rdata),
        .o_we        (part_we),
        .o_waddr     (part_waddr),
        .o_wdata     (part_wdata),
        .o_raddr     (part_raddr),
        .o_pos       (part_pos),
        .o_sts       (part_sts)
    );

    // command control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= T_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // a result moving in from T_DONE keeps the register full
            if (r_out_valid && !i_stall && r_state != T_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (in_accept) begin
                        r_res_val <= '0;
                        r_res_pos <= '0;
                        r_res_st  <= 1'b0;
                        case (cmd)
                            CMD_WRITE: begin
                                r_res_st <= !idx_ok;
                                r_state  <= T_DONE;
                            end
                            CMD_READ: begin
                                r_res_st <= !idx_ok;
                                r_state  <= idx_ok ? T_READ : T_DONE;
                            end
                            CMD_PART: begin
                                r_res_st <= !rng_ok;
                                r_state  <= rng_ok ? T_PART : T_DONE;
                            end
                            default: begin
                                // unknown command
                                r_res_st <= 1'b1;
                                r_state  <= T_DONE;
                            end
                        endcase
                    end
                end
                T_READ: begin
                    // store data for the accepted read is out now
                    r_res_val <= DATA_W'($signed(mem_rdata));
                    r_state   <= T_DONE;
                end
                T_PART: begin
                    if (part_sts.done) begin
                        r_res_pos <= INDEX_W'(part_pos);
                        r_state   <= T_DONE;
                    end
                end
                T_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_val   <= r_res_val;
                        r_out_pos   <= r_res_pos;
                        r_out_st    <= r_res_st;
                        r_state     <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_read_value     = r_out_val;
    assign o_pivot_position = r_out_pos;
    assign o_status         = r_out_st;

    // partition engine finishes only under a partition item
    a_done_in_part: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        part_sts.done |-> (r_state == T_PART))
        else $error("partition done outside partition item");

    // no new item while the engine owns the store
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        part_sts.busy |-> o_stall)
        else $error("item accepted while partition busy");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_read_value == '0 && o_pivot_position == '0))
        else $error("error result with nonzero fields");

    // a partition result loads the engine's pivot index
    a_pos_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == T_PART && part_sts.done) |=> (r_res_pos == INDEX_W'($past(part_pos))))
        else $error("pivot position not captured");

endmodule
